>>> src/priority_slot_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Priority slot scheduler: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SLOT_SCHEDULER_DEFINES_SVH
`define PRIORITY_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PSCHED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PSCHED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/psched_pkg.sv
// ----------------------------------------------------------------------------
// Priority slot scheduler package
// Widths, command and slot state codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package psched_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int ID_W  = 22;
    localparam int CMD_W = 3;
    localparam int PRI_W = 4;
    localparam int ST_W  = 3;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] MAX_RUN_RESET = 5'd3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_RUN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KILL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXITED = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

    // Slot states
    localparam logic [ST_W-1:0] SLOT_RUNNING    = 3'd0;
    localparam logic [ST_W-1:0] SLOT_READY      = 3'd1;
    localparam logic [ST_W-1:0] SLOT_STOPPED    = 3'd2;
    localparam logic [ST_W-1:0] SLOT_TERMINATED = 3'd3;
    localparam logic [ST_W-1:0] SLOT_UNUSED     = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch command, clear scan accumulators
        logic scan1;     // pre-command scan step
        logic apply;     // update slots for the command
        logic scan2;     // post-command scan step
        logic promote;   // promote the first ready slot if room
        logic load_out;  // move result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/psched_ctrl.sv
// ----------------------------------------------------------------------------
// Priority slot scheduler controller
// Sequences accept, two slot scans, update, promotion and result hand-off.
// ----------------------------------------------------------------------------
module psched_ctrl
    import psched_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  ctrl_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_PROMO = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // hold off the input while reset is applied
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    ctrl_cmd.capture = 1'b1;
                    state_next       = S_SCAN1;
                end
            end
            S_SCAN1: begin
                ctrl_cmd.scan1 = 1'b1;
                if (dp_status.scan_last) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                ctrl_cmd.apply = 1'b1;
                state_next     = S_SCAN2;
            end
            S_SCAN2: begin
                ctrl_cmd.scan2 = 1'b1;
                if (dp_status.scan_last) begin
                    state_next = S_PROMO;
                end
            end
            S_PROMO: begin
                ctrl_cmd.promote = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (dp_status.out_free) begin
                    ctrl_cmd.load_out = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/psched_dp.sv
// ----------------------------------------------------------------------------
// Priority slot scheduler datapath
// Slot table, scan accumulators, command update, result and output registers.
// ----------------------------------------------------------------------------
module psched_dp
    import psched_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_cmd_t        ctrl_cmd,
    output dp_status_t       dp_status,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic [CMD_W-1:0] s_command,
    input  logic [ID_W-1:0]  s_task_id,
    input  logic [PRI_W-1:0] s_priority_req,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_status,
    output logic             m_pause_valid,
    output logic [ID_W-1:0]  m_pause_id,
    output logic             m_continue_valid,
    output logic [ID_W-1:0]  m_continue_id,
    output logic             m_promote_valid,
    output logic [ID_W-1:0]  m_promote_id,
    output logic [ID_W-1:0]  m_query_id,
    output logic [ST_W-1:0]  m_query_state
);

    // slot table
    logic [ID_W-1:0]  slot_id_reg [SLOTS];
    logic [ST_W-1:0]  slot_st_reg [SLOTS];
    logic [CFG_W-1:0] max_run_reg;
    logic             out_valid_reg;

    // latched command
    logic [CMD_W-1:0] cmd_reg;
    logic [ID_W-1:0]  id_reg;
    logic [PRI_W-1:0] pr_reg;

    // scan state
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             hi_run_valid_reg;
    logic [IDX_W-1:0] hi_run_idx_reg;
    logic [ID_W-1:0]  hi_run_id_reg;
    logic             rdy_found_reg;
    logic [IDX_W-1:0] rdy_idx_reg;
    logic [ID_W-1:0]  rdy_id_reg;

    // result
    logic             status_reg;
    logic             pv_reg;
    logic [ID_W-1:0]  pid_reg;
    logic             cv_reg;
    logic [ID_W-1:0]  cid_reg;
    logic             mv_reg;
    logic [ID_W-1:0]  mid_reg;
    logic [ID_W-1:0]  qid_reg;
    logic [ST_W-1:0]  qst_reg;

    // output register
    logic             o_status_reg;
    logic             o_pv_reg;
    logic [ID_W-1:0]  o_pid_reg;
    logic             o_cv_reg;
    logic [ID_W-1:0]  o_cid_reg;
    logic             o_mv_reg;
    logic [ID_W-1:0]  o_mid_reg;
    logic [ID_W-1:0]  o_qid_reg;
    logic [ST_W-1:0]  o_qst_reg;

    logic [ID_W-1:0]  rd_id;
    logic [ST_W-1:0]  rd_st;
    logic             scan_last;
    logic [IDX_W-1:0] tgt_idx;
    logic             run_ok;
    logic             victim_ok;
    logic             can_run;

    // single read port at the scan index
    assign rd_id = slot_id_reg[idx_reg];
    assign rd_st = slot_st_reg[idx_reg];

    assign scan_last = (idx_reg == IDX_W'(SLOTS - 1));
    assign tgt_idx   = (cmd_reg == CMD_RUN) ? IDX_W'(pr_reg) : hit_idx_reg;
    assign run_ok    = (id_reg != '0) && (32'(pr_reg) < SLOTS);
    // highest running slot beyond the target is the preemption victim
    assign victim_ok = hi_run_valid_reg && (hi_run_idx_reg > tgt_idx);
    assign can_run   = (32'(cnt_reg) < 32'(max_run_reg));

    assign dp_status.scan_last = scan_last;
    assign dp_status.out_free  = !out_valid_reg || m_ready;

    // slot table, limit and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_id_reg[i] <= '0;
                slot_st_reg[i] <= SLOT_UNUSED;
            end
            max_run_reg   <= MAX_RUN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_run_reg <= cfg_wdata;
            end
            if (ctrl_cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ctrl_cmd.apply) begin
                case (cmd_reg)
                    CMD_RUN: begin
                        if (run_ok) begin
                            slot_id_reg[tgt_idx] <= id_reg;
                            if (can_run) begin
                                slot_st_reg[tgt_idx] <= SLOT_RUNNING;
                            end else if (!victim_ok) begin
                                slot_st_reg[tgt_idx] <= SLOT_READY;
                            end else begin
                                slot_st_reg[hi_run_idx_reg] <= SLOT_READY;
                                slot_st_reg[tgt_idx]        <= SLOT_RUNNING;
                            end
                        end
                    end
                    CMD_KILL, CMD_EXITED: begin
                        if (hit_reg) begin
                            slot_st_reg[tgt_idx] <= SLOT_TERMINATED;
                        end
                    end
                    CMD_STOP: begin
                        if (hit_reg) begin
                            slot_st_reg[tgt_idx] <= SLOT_STOPPED;
                        end
                    end
                    CMD_RESUME: begin
                        if (hit_reg) begin
                            if (can_run) begin
                                slot_st_reg[tgt_idx] <= SLOT_RUNNING;
                            end else if (victim_ok) begin
                                slot_st_reg[hi_run_idx_reg] <= SLOT_READY;
                                slot_st_reg[tgt_idx]        <= SLOT_RUNNING;
                            end else begin
                                slot_st_reg[tgt_idx] <= SLOT_READY;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (ctrl_cmd.promote && rdy_found_reg && can_run) begin
                slot_st_reg[rdy_idx_reg] <= SLOT_RUNNING;
            end
        end
    end

    // command, scan accumulators and result fields
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.capture) begin
            cmd_reg          <= s_command;
            id_reg           <= s_task_id;
            pr_reg           <= s_priority_req;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            hit_reg          <= 1'b0;
            hi_run_valid_reg <= 1'b0;
            status_reg       <= 1'b0;
            pv_reg           <= 1'b0;
            pid_reg          <= '0;
            cv_reg           <= 1'b0;
            cid_reg          <= '0;
            mv_reg           <= 1'b0;
            mid_reg          <= '0;
            qid_reg          <= '0;
            qst_reg          <= SLOT_UNUSED;
        end
        if (ctrl_cmd.scan1) begin
            idx_reg <= scan_last ? '0 : idx_reg + IDX_W'(1);
            if (rd_st == SLOT_RUNNING) begin
                cnt_reg          <= cnt_reg + CNT_W'(1);
                hi_run_valid_reg <= 1'b1;
                hi_run_idx_reg   <= idx_reg;
                hi_run_id_reg    <= rd_id;
            end
            if (!hit_reg && (id_reg != '0) && (rd_id == id_reg)) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if ((cmd_reg == CMD_QUERY) && (32'(idx_reg) == 32'(pr_reg))) begin
                qid_reg <= rd_id;
                qst_reg <= rd_st;
            end
        end
        if (ctrl_cmd.apply) begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rdy_found_reg <= 1'b0;
            case (cmd_reg)
                CMD_RUN: begin
                    if (!run_ok) begin
                        status_reg <= 1'b1;
                    end else if (!can_run) begin
                        pv_reg  <= 1'b1;
                        pid_reg <= victim_ok ? hi_run_id_reg : id_reg;
                    end
                end
                CMD_KILL, CMD_EXITED: begin
                    status_reg <= !hit_reg;
                end
                CMD_STOP: begin
                    status_reg <= !hit_reg;
                    if (hit_reg) begin
                        pv_reg  <= 1'b1;
                        pid_reg <= id_reg;
                    end
                end
                CMD_RESUME: begin
                    status_reg <= !hit_reg;
                    if (hit_reg && (can_run || victim_ok)) begin
                        cv_reg  <= 1'b1;
                        cid_reg <= id_reg;
                    end
                    if (hit_reg && !can_run && victim_ok) begin
                        pv_reg  <= 1'b1;
                        pid_reg <= hi_run_id_reg;
                    end
                end
                default: begin
                end
            endcase
        end
        if (ctrl_cmd.scan2) begin
            idx_reg <= scan_last ? '0 : idx_reg + IDX_W'(1);
            if (rd_st == SLOT_RUNNING) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (!rdy_found_reg && (rd_st == SLOT_READY)) begin
                rdy_found_reg <= 1'b1;
                rdy_idx_reg   <= idx_reg;
                rdy_id_reg    <= rd_id;
            end
        end
        if (ctrl_cmd.promote && rdy_found_reg && can_run) begin
            mv_reg  <= 1'b1;
            mid_reg <= rdy_id_reg;
        end
        if (ctrl_cmd.load_out) begin
            o_status_reg <= status_reg;
            o_pv_reg     <= pv_reg;
            o_pid_reg    <= pid_reg;
            o_cv_reg     <= cv_reg;
            o_cid_reg    <= cid_reg;
            o_mv_reg     <= mv_reg;
            o_mid_reg    <= mid_reg;
            o_qid_reg    <= qid_reg;
            o_qst_reg    <= qst_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = o_status_reg;
    assign m_pause_valid    = o_pv_reg;
    assign m_pause_id       = o_pid_reg;
    assign m_continue_valid = o_cv_reg;
    assign m_continue_id    = o_cid_reg;
    assign m_promote_valid  = o_mv_reg;
    assign m_promote_id     = o_mid_reg;
    assign m_query_id       = o_qid_reg;
    assign m_query_state    = o_qst_reg;

endmodule

>>> src/priority_slot_scheduler.sv
// ----------------------------------------------------------------------------
// Priority slot scheduler
// Task slot table by priority with admission, preemption and promotion.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives exactly one result item. The
// command is latched at the edge that accepts it. It then goes through a
// scan of the slot table that counts running tasks and finds the addressed
// task and the preemption victim, an update of the table, a second scan
// that counts again and finds the first ready slot, promotion, and the load
// of the output register, after which its result appears on m_valid. The
// table has one read port, so each scan visits one slot per cycle. The result
// waits in its own register and s_ready rises again in the cycle after the
// load, so a new command is accepted only once the previous one is done; a
// command that finishes while the previous result is still unread holds until
// m_ready. s_ready stays low while aresetn is low. max_running is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module priority_slot_scheduler
    import psched_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    // command channel
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] s_command,
    input  logic [ID_W-1:0]  s_task_id,
    input  logic [PRI_W-1:0] s_priority_req,
    // result channel
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_status,
    output logic             m_pause_valid,
    output logic [ID_W-1:0]  m_pause_id,
    output logic             m_continue_valid,
    output logic [ID_W-1:0]  m_continue_id,
    output logic             m_promote_valid,
    output logic [ID_W-1:0]  m_promote_id,
    output logic [ID_W-1:0]  m_query_id,
    output logic [ST_W-1:0]  m_query_state
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // Sequencer: idle, scan, update, scan, promote, hand off.
    psched_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    // Slot table, scan accumulators and the output register.
    psched_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl_cmd         (ctrl_cmd),
        .dp_status        (dp_status),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_command        (s_command),
        .s_task_id        (s_task_id),
        .s_priority_req   (s_priority_req),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_pause_valid    (m_pause_valid),
        .m_pause_id       (m_pause_id),
        .m_continue_valid (m_continue_valid),
        .m_continue_id    (m_continue_id),
        .m_promote_valid  (m_promote_valid),
        .m_promote_id     (m_promote_id),
        .m_query_id       (m_query_id),
        .m_query_state    (m_query_state)
    );

endmodule

>>> src/psched_checker.sv
// ----------------------------------------------------------------------------
// Priority slot scheduler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_slot_scheduler_defines.svh"

module psched_checker
    import psched_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_status,
    input logic             m_pause_valid,
    input logic [ID_W-1:0]  m_pause_id,
    input logic             m_continue_valid,
    input logic [ID_W-1:0]  m_continue_id,
    input logic [ID_W-1:0]  m_promote_id
);

    // id fields read zero when their flag is clear
    `PSCHED_ASSERT_NOW(a_pause_id_zero, m_valid && !m_pause_valid, m_pause_id == '0, "pause id without pause")
    `PSCHED_ASSERT_NOW(a_cont_id_zero, m_valid && !m_continue_valid, m_continue_id == '0, "continue id without continue")
    // a missed lookup or rejected run pauses and continues nothing
    `PSCHED_ASSERT_NOW(a_miss_quiet, m_valid && m_status, !m_pause_valid && !m_continue_valid, "action on failed command")
    // one command at a time: busy right after acceptance
    `PSCHED_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "accepted while busy")
    // a stalled result holds
    `PSCHED_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_promote_id), "result dropped under stall")

endmodule

bind priority_slot_scheduler psched_checker u_psched_checker (.*);
